// ===== hw/rtl/sacf_pkg.sv =====
// Shared types and constants of the set-associative cache lookup core.
package sacf_pkg;

   // Widths fixed by the item and register formats.
   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned COUNT_W    = 32;
   localparam int unsigned WAYS_W     = 2;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned RSP_W      = 72;

   // Register index taken from byte address bit 2.
   localparam logic [0:0] REG_WAYS_LOG2 = 1'b0;

   // Saturation value of the running counters.
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Control states of the lookup core.
   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_LOOKUP = 3'b100
   } state_type;

endpackage

// ===== hw/rtl/sacf_ram.sv =====
// Simple dual-port synchronous memory with a registered read port.
module sacf_ram #(
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = 4
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sacf_csr.sv =====
// Configuration register block on the APB-style port.
module sacf_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sacf_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sacf_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sacf_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready,
   output logic [sacf_pkg::WAYS_W-1:0]        ways_log2
);

   logic [sacf_pkg::WAYS_W-1:0] ways_log2_ff;
   logic [sacf_pkg::WAYS_W-1:0] ways_log2_in;
   logic                        wr_hit;
   logic                        rd_hit;

   // Register decode on the word index.
   assign wr_hit = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[2] == sacf_pkg::REG_WAYS_LOG2);
   assign rd_hit = (csr_paddr[2] == sacf_pkg::REG_WAYS_LOG2);

   always_comb begin
      ways_log2_in = ways_log2_ff;
      if (wr_hit) begin
         ways_log2_in = csr_pwdata[sacf_pkg::WAYS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ways_log2_ff <= '0;
      end else begin
         ways_log2_ff <= ways_log2_in;
      end
   end

   // Read-back and an always-ready slave.
   assign csr_prdata = rd_hit ? sacf_pkg::CSR_DATA_W'(ways_log2_ff) : '0;
   assign csr_pready = 1'b1;
   assign ways_log2  = ways_log2_ff;

endmodule

// ===== hw/rtl/set_assoc_cache_fifo_lookup_core.sv =====
// Top level: set-associative tag lookup with FIFO replacement and hit/miss counters.
//
//  channel  | direction | handshake              | payload
//  req_     | in        | req_tvalid/req_tready  | byte address
//  rsp_     | out       | rsp_tvalid/rsp_tready  | hit flag, hit count, miss count
//  csr_     | in        | psel/penable/pwrite    | associativity register
//
// The tag row and FIFO pointer of an item are read from their memories in the accept
// cycle, then compared and, on a miss, updated and written back in the lookup stage.
// One item is in flight at a time; the result register lets the next item be taken
// while an earlier result still waits. After reset a clearing pass zeroes the tag rows
// and pointers; no item is taken during it. A stalled result holds the lookup stage
// until the result register frees up.
// LINES and BLOCK_BYTES must be powers of two; the block itself does not enforce it.
module set_assoc_cache_fifo_lookup_core #(
   parameter int unsigned LINES       = 64,
   parameter int unsigned BLOCK_BYTES = 32,
   parameter int unsigned ADDR_BITS   = 32,
   parameter int unsigned MAX_WAYS    = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   // tdata: byte_address[31:0]
   input  logic [sacf_pkg::ADDR_W-1:0]      req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: hit[0], hit_count[32:1], miss_count[64:33], zero fill[71:65]
   output logic [sacf_pkg::RSP_W-1:0]       rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [sacf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [sacf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [sacf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   // Geometry derived from the parameters.
   localparam int unsigned AW       = (ADDR_BITS < sacf_pkg::ADDR_W) ? ADDR_BITS
                                                                     : sacf_pkg::ADDR_W;
   localparam int unsigned OFF      = $clog2(BLOCK_BYTES + 1) - 1;
   localparam int unsigned LL       = $clog2(LINES + 1) - 1;
   localparam int unsigned WLM_RAW  = $clog2(MAX_WAYS + 1) - 1;
   localparam int unsigned WLM      = (WLM_RAW < LL) ? WLM_RAW : LL;
   localparam int unsigned LANES    = 1 << WLM;
   localparam int unsigned LANE_W   = (WLM > 0) ? WLM : 1;
   localparam int unsigned ROW_BITS = LL - WLM;
   localparam int unsigned ROWS     = 1 << ROW_BITS;
   localparam int unsigned ROW_W    = (ROW_BITS > 0) ? ROW_BITS : 1;
   localparam int unsigned LA_W     = AW - OFF;
   localparam int unsigned TAG_W    = (LA_W > ROW_BITS) ? (LA_W - ROW_BITS) : 1;
   localparam int unsigned LAX_W    = LA_W + LL;
   localparam int unsigned SB_W     = $clog2(LL + 1);
   localparam int unsigned ENTRY_W  = TAG_W + 1;
   localparam int unsigned ROW_DW   = LANES * ENTRY_W;
   localparam int unsigned PAD_W    = sacf_pkg::RSP_W - 1 - 2 * sacf_pkg::COUNT_W;
   localparam logic [LANE_W-1:0] LANE_MASK = LANE_W'(LANES - 1);

   // Control and datapath registers.
   sacf_pkg::state_type              state_ff, state_in;
   logic [LL-1:0]                    clr_ff, clr_in;
   logic [LL-1:0]                    set_ff;
   logic [TAG_W-1:0]                 tag_ff;
   logic                             out_valid_ff, out_valid_in;
   logic                             out_hit_ff;
   logic [sacf_pkg::COUNT_W-1:0]     hit_cnt_ff, hit_cnt_in;
   logic [sacf_pkg::COUNT_W-1:0]     miss_cnt_ff, miss_cnt_in;

   logic [sacf_pkg::WAYS_W-1:0]      ways_cfg;
   logic [sacf_pkg::WAYS_W-1:0]      wl;
   logic                             accept;
   logic                             done;

   // Accept-side address split.
   logic [LAX_W-1:0]                 la_ext;
   logic [LL-1:0]                    set_mask;
   logic [LL-1:0]                    set_acc;
   logic [SB_W-1:0]                  set_bits;
   logic [LAX_W-1:0]                 tag_full;
   logic [LL-1:0]                    line_acc;

   // Lookup-side signals.
   logic [LL-1:0]                    line_lk;
   logic [LANE_W-1:0]                lane_base;
   logic [LANE_W-1:0]                way_mask;
   logic [LANE_W-1:0]                ptr_cur;
   logic [LANE_W-1:0]                victim;
   logic [LANE_W-1:0]                ptr_next;
   logic [LANES-1:0][ENTRY_W-1:0]    row_rd;
   logic [LANES-1:0][ENTRY_W-1:0]    row_new;
   logic [LANES-1:0]                 lane_match;
   logic                             hit;

   // Memory ports.
   logic [ROW_W-1:0]                 tag_rd_addr;
   logic [ROW_DW-1:0]                tag_rd_data;
   logic                             tag_we;
   logic [ROW_W-1:0]                 tag_wr_addr;
   logic [ROW_DW-1:0]                tag_wr_data;
   logic [LANE_W-1:0]                ptr_rd_data;
   logic                             ptr_we;
   logic [LL-1:0]                    ptr_wr_addr;
   logic [LANE_W-1:0]                ptr_wr_data;

   // Configuration register.
   sacf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .ways_log2   (ways_cfg)
   );

   // Associativity saturated to what the geometry allows.
   assign wl = (ways_cfg > sacf_pkg::WAYS_W'(WLM)) ? sacf_pkg::WAYS_W'(WLM) : ways_cfg;

   // Handshake and completion of the lookup stage.
   assign req_tready = (state_ff == sacf_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign done       = (state_ff == sacf_pkg::ST_LOOKUP) && (!out_valid_ff || rsp_tready);

   // Split the address into set and tag under the current grouping.
   always_comb begin
      la_ext   = LAX_W'(req_tdata[AW-1:OFF]);
      set_mask = {LL{1'b1}} >> wl;
      set_acc  = la_ext[LL-1:0] & set_mask;
      set_bits = SB_W'(LL) - SB_W'(wl);
      tag_full = la_ext >> set_bits;
      line_acc = set_acc << wl;
   end

   assign tag_rd_addr = ROW_W'(line_acc >> WLM);

   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff <= set_acc;
         tag_ff <= TAG_W'(tag_full);
      end
   end

   // Compare the ways of the set and pick the FIFO victim.
   always_comb begin
      line_lk   = set_ff << wl;
      lane_base = LANE_W'(line_lk) & LANE_MASK;
      way_mask  = ~({LANE_W{1'b1}} << wl) & LANE_MASK;
      row_rd    = tag_rd_data;
      for (int l = 0; l < LANES; l++) begin
         lane_match[l] = ((((LANE_W'(l) ^ lane_base) & ~way_mask) & LANE_MASK) == '0) &&
                         row_rd[l][TAG_W] && (row_rd[l][TAG_W-1:0] == tag_ff);
      end
      hit      = |lane_match;
      ptr_cur  = ptr_rd_data & way_mask;
      victim   = lane_base | ptr_cur;
      ptr_next = (ptr_cur + LANE_W'(1)) & way_mask;
      row_new  = row_rd;
      row_new[victim] = {1'b1, tag_ff};
   end

   // Write-back: the clearing pass, or the victim row and pointer on a miss.
   always_comb begin
      if (state_ff == sacf_pkg::ST_CLEAR) begin
         tag_we      = 1'b1;
         tag_wr_addr = ROW_W'(clr_ff >> WLM);
         tag_wr_data = '0;
         ptr_we      = 1'b1;
         ptr_wr_addr = clr_ff;
         ptr_wr_data = '0;
      end else begin
         tag_we      = done && !hit;
         tag_wr_addr = ROW_W'(line_lk >> WLM);
         tag_wr_data = row_new;
         ptr_we      = done && !hit;
         ptr_wr_addr = set_ff;
         ptr_wr_data = ptr_next;
      end
   end

   sacf_ram #(
      .WIDTH  (ROW_DW),
      .DEPTH  (ROWS),
      .ADDR_W (ROW_W)
   ) u_tag_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (tag_rd_addr),
      .rd_data (tag_rd_data),
      .wr_en   (tag_we),
      .wr_addr (tag_wr_addr),
      .wr_data (tag_wr_data)
   );

   sacf_ram #(
      .WIDTH  (LANE_W),
      .DEPTH  (LINES),
      .ADDR_W (LL)
   ) u_ptr_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (set_acc),
      .rd_data (ptr_rd_data),
      .wr_en   (ptr_we),
      .wr_addr (ptr_wr_addr),
      .wr_data (ptr_wr_data)
   );

   // Sequencer: clearing pass, idle, lookup.
   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         sacf_pkg::ST_CLEAR: begin
            clr_in = clr_ff + LL'(1);
            if (clr_ff == LL'(LINES - 1)) begin
               state_in = sacf_pkg::ST_IDLE;
            end
         end
         sacf_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = sacf_pkg::ST_LOOKUP;
            end
         end
         sacf_pkg::ST_LOOKUP: begin
            if (done) begin
               state_in = sacf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sacf_pkg::ST_CLEAR;
         end
      endcase
   end

   // Saturating counters and the result register.
   always_comb begin
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (done) begin
         out_valid_in = 1'b1;
         if (hit) begin
            if (hit_cnt_ff != sacf_pkg::COUNT_MAX) begin
               hit_cnt_in = hit_cnt_ff + sacf_pkg::COUNT_W'(1);
            end
         end else begin
            if (miss_cnt_ff != sacf_pkg::COUNT_MAX) begin
               miss_cnt_in = miss_cnt_ff + sacf_pkg::COUNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sacf_pkg::ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         out_valid_ff <= out_valid_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         out_hit_ff <= hit;
      end
   end

   // The counters only move when a result is loaded, so they are read directly.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {PAD_W'(0), miss_cnt_ff, hit_cnt_ff, out_hit_ff};

`ifndef SYNTH
   // An accepted item always moves on to the lookup stage.
   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == sacf_pkg::ST_LOOKUP))
      else $error("accepted item did not enter the lookup stage");

   // A hit never rewrites the tag row or the FIFO pointer.
   a_hit_no_write: assert property (@(posedge clock) disable iff (reset)
      (done && hit) |-> (!tag_we && !ptr_we))
      else $error("tag memory written on a hit");

   // Hit and miss counts never move together.
   a_one_counter: assert property (@(posedge clock) disable iff (reset)
      (hit_cnt_ff != $past(hit_cnt_ff)) |-> (miss_cnt_ff == $past(miss_cnt_ff)))
      else $error("hit and miss counters changed together");

   // Counters change only when a result is loaded.
   a_count_on_done: assert property (@(posedge clock) disable iff (reset)
      !done |=> ($stable(hit_cnt_ff) && $stable(miss_cnt_ff)))
      else $error("counter changed without a completed lookup");
`endif

endmodule
